/* design/fpt_pkg.sv */
// Shared types and constants for the frame point transform.
// Self-contained; every other design file depends on it.
package fpt_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int COEF_WIDTH_DEF  = 16;
   localparam int QUEUE_DEPTH     = 4;
   localparam int CSR_INDEX_WIDTH = 3;

   typedef enum logic [1:0] {
      OP_BASE_TO_SPACE     = 2'd0,
      OP_SPACE_TO_BASE     = 2'd1,
      OP_BASE_TO_SPACE_DIM = 2'd2,
      OP_SPACE_TO_BASE_DIM = 2'd3
   } op_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_AXIS_X   = 3'd0,
      REG_AXIS_Y   = 3'd1,
      REG_AXIS_Z   = 3'd2,
      REG_OFFSET_X = 3'd3,
      REG_OFFSET_Y = 3'd4,
      REG_OFFSET_Z = 3'd5
   } csr_reg_type;

   // decoded operation of one request, handed from the front queue to the datapath
   typedef struct packed {
      logic sub_offset;
      logic add_offset;
      logic use_abs;
      logic transpose;
   } op_flags_type;

endpackage

/* design/fpt_req_if.sv */
// Request channel of the frame point transform: valid/ready, the operation and the point.
// Depends on fpt_pkg.
interface fpt_req_if #(
   parameter int COORD_WIDTH = fpt_pkg::COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   fpt_pkg::op_type               operation;
   logic signed [COORD_WIDTH-1:0] x_in;
   logic signed [COORD_WIDTH-1:0] y_in;
   logic signed [COORD_WIDTH-1:0] z_in;

   modport source (output valid, operation, x_in, y_in, z_in, input ready);
   modport sink   (input valid, operation, x_in, y_in, z_in, output ready);
endinterface

/* design/fpt_rsp_if.sv */
// Result channel of the frame point transform: valid/ready, the point and a saturation flag.
// Depends on fpt_pkg.
interface fpt_rsp_if #(
   parameter int COORD_WIDTH = fpt_pkg::COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] x_out;
   logic signed [COORD_WIDTH-1:0] y_out;
   logic signed [COORD_WIDTH-1:0] z_out;
   logic                          saturated;

   modport source (output valid, x_out, y_out, z_out, saturated, input ready);
   modport sink   (input valid, x_out, y_out, z_out, saturated, output ready);
endinterface

/* design/frame_point_transform_top.sv */
// Top level of the frame point transform: register file, front queue, datapath.
// Depends on fpt_pkg, fpt_req_if, fpt_rsp_if, fpt_csr, fpt_front and fpt_back.
//
// Converts one signed Q19.12 point per request between the base frame and the
// configured frame (A*(p-offset), A^T*p+offset, or the abs-valued dimension
// forms), rounding each product to nearest and saturating each component.
// One request is taken every cycle while the front queue is not full. A four-entry
// queue sits between the request side and the four-stage datapath (operand
// select, split multiply, round, sum and clip), so a stalled result only backs
// up requests once the queue is full. Write the configuration registers only
// while idle.
module frame_point_transform_top #(
   parameter int COORD_WIDTH = fpt_pkg::COORD_WIDTH_DEF,
   parameter int COEF_WIDTH  = fpt_pkg::COEF_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   fpt_req_if.sink                             req_chan,
   fpt_rsp_if.source                           rsp_chan,
   input  logic                                csr_wr_en,
   input  logic [fpt_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [((3*COEF_WIDTH > COORD_WIDTH) ? 3*COEF_WIDTH : COORD_WIDTH)-1:0] csr_wdata
);
   import fpt_pkg::*;

   logic [3*COEF_WIDTH-1:0]       axis_row [3];
   logic signed [COORD_WIDTH-1:0] offset   [3];
   logic                          q_valid;
   op_flags_type                  q_flags;
   logic signed [COORD_WIDTH-1:0] q_point  [3];
   logic                          q_pop;

   fpt_csr #(
      .COORD_WIDTH (COORD_WIDTH),
      .COEF_WIDTH  (COEF_WIDTH)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .axis_row  (axis_row),
      .offset    (offset)
   );

   fpt_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_valid  (q_valid),
      .q_flags  (q_flags),
      .q_point  (q_point),
      .q_pop    (q_pop)
   );

   fpt_back #(
      .COORD_WIDTH (COORD_WIDTH),
      .COEF_WIDTH  (COEF_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_flags  (q_flags),
      .q_point  (q_point),
      .q_pop    (q_pop),
      .axis_row (axis_row),
      .offset   (offset),
      .rsp_chan (rsp_chan)
   );

endmodule

/* design/fpt_csr.sv */
// Configuration registers: three axis rows and the frame offset.
// Depends on fpt_pkg.
module fpt_csr #(
   parameter int COORD_WIDTH = fpt_pkg::COORD_WIDTH_DEF,
   parameter int COEF_WIDTH  = fpt_pkg::COEF_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [fpt_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [((3*COEF_WIDTH > COORD_WIDTH) ? 3*COEF_WIDTH : COORD_WIDTH)-1:0] csr_wdata,
   output logic [3*COEF_WIDTH-1:0]                axis_row [3],
   output logic signed [COORD_WIDTH-1:0]          offset   [3]
);
   import fpt_pkg::*;

   localparam int RowWidth = 3 * COEF_WIDTH;
   localparam logic [RowWidth-1:0] Unit = RowWidth'(1) << (COEF_WIDTH - 2);

   logic [RowWidth-1:0]          axis_row_ff [3];
   logic signed [COORD_WIDTH-1:0] offset_ff  [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            axis_row_ff[r] <= Unit << (r * COEF_WIDTH);
            offset_ff[r]   <= '0;
         end
      end else if (csr_wr_en) begin
         case (csr_reg_type'(csr_index))
            REG_AXIS_X:   axis_row_ff[0] <= csr_wdata[RowWidth-1:0];
            REG_AXIS_Y:   axis_row_ff[1] <= csr_wdata[RowWidth-1:0];
            REG_AXIS_Z:   axis_row_ff[2] <= csr_wdata[RowWidth-1:0];
            REG_OFFSET_X: offset_ff[0]   <= $signed(csr_wdata[COORD_WIDTH-1:0]);
            REG_OFFSET_Y: offset_ff[1]   <= $signed(csr_wdata[COORD_WIDTH-1:0]);
            REG_OFFSET_Z: offset_ff[2]   <= $signed(csr_wdata[COORD_WIDTH-1:0]);
            default: ;
         endcase
      end
   end

   assign axis_row = axis_row_ff;
   assign offset   = offset_ff;

endmodule

/* design/fpt_front.sv */
// Front end: accepts requests, decodes the operation and queues the point.
// Depends on fpt_pkg and fpt_req_if.
module fpt_front #(
   parameter int COORD_WIDTH = fpt_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   fpt_req_if.sink                       req_chan,
   output logic                          q_valid,
   output fpt_pkg::op_flags_type         q_flags,
   output logic signed [COORD_WIDTH-1:0] q_point [3],
   input  logic                          q_pop
);
   import fpt_pkg::*;

   localparam int PtrWidth   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CountWidth = $clog2(QUEUE_DEPTH + 1);

   op_flags_type                  flags_mem_ff [QUEUE_DEPTH];
   logic signed [COORD_WIDTH-1:0] point_mem_ff [QUEUE_DEPTH][3];
   logic [PtrWidth-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]         count_ff, count_in;
   op_flags_type                  dec_flags;
   logic                          push;
   logic                          pop;

   always_comb begin
      dec_flags = '0;
      case (req_chan.operation)
         OP_BASE_TO_SPACE:     dec_flags.sub_offset = 1'b1;
         OP_SPACE_TO_BASE: begin
            dec_flags.add_offset = 1'b1;
            dec_flags.transpose  = 1'b1;
         end
         OP_BASE_TO_SPACE_DIM: dec_flags.use_abs = 1'b1;
         OP_SPACE_TO_BASE_DIM: begin
            dec_flags.use_abs   = 1'b1;
            dec_flags.transpose = 1'b1;
         end
         default: dec_flags = '0;
      endcase
   end

   assign req_chan.ready = (count_ff != CountWidth'(QUEUE_DEPTH));
   assign push = req_chan.valid && req_chan.ready;
   assign pop  = q_pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         flags_mem_ff[wr_ptr_ff]    <= dec_flags;
         point_mem_ff[wr_ptr_ff][0] <= req_chan.x_in;
         point_mem_ff[wr_ptr_ff][1] <= req_chan.y_in;
         point_mem_ff[wr_ptr_ff][2] <= req_chan.z_in;
      end
   end

   assign q_valid = (count_ff != '0);
   assign q_flags = flags_mem_ff[rd_ptr_ff];
   assign q_point = point_mem_ff[rd_ptr_ff];

endmodule

/* design/fpt_back.sv */
// Back end: operand select, split multiplies, per-term rounding, sum and saturate.
// Depends on fpt_pkg and fpt_rsp_if.
module fpt_back #(
   parameter int COORD_WIDTH = fpt_pkg::COORD_WIDTH_DEF,
   parameter int COEF_WIDTH  = fpt_pkg::COEF_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  fpt_pkg::op_flags_type         q_flags,
   input  logic signed [COORD_WIDTH-1:0] q_point  [3],
   output logic                          q_pop,
   input  logic [3*COEF_WIDTH-1:0]       axis_row [3],
   input  logic signed [COORD_WIDTH-1:0] offset   [3],
   fpt_rsp_if.source                     rsp_chan
);
   import fpt_pkg::*;

   localparam int FracBits = COEF_WIDTH - 2;
   localparam int CxWidth  = COORD_WIDTH + 1;          // operand after offset subtract
   localparam int KxWidth  = COEF_WIDTH + 1;           // coefficient after abs
   localparam int LoWidth  = CxWidth / 2;
   localparam int HiWidth  = CxWidth - LoWidth;
   localparam int LoPWidth = LoWidth + 1 + KxWidth;
   localparam int HiPWidth = HiWidth + KxWidth;
   localparam int PWidth   = CxWidth + KxWidth;
   localparam int TWidth   = PWidth - FracBits;
   localparam int AWidth   = TWidth + 3;
   localparam logic signed [PWidth-1:0] Half = PWidth'(1) <<< (FracBits - 1);
   localparam logic signed [COORD_WIDTH-1:0] CoordMax = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] CoordMin = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   logic adv;

   // stage 1: operands
   logic signed [CxWidth-1:0]  c_ff [3], c_in [3];
   logic signed [KxWidth-1:0]  k_ff [3][3], k_in [3][3];
   // stage 2: partial products
   logic signed [LoPWidth-1:0] lo_p_ff [3][3];
   logic signed [HiPWidth-1:0] hi_p_ff [3][3];
   // stage 3: rounded terms
   logic signed [TWidth-1:0]   term_ff [3][3], term_in [3][3];
   logic                       v1_ff, v2_ff, v3_ff;
   logic                       add1_ff, add2_ff, add3_ff;
   // output register
   logic signed [COORD_WIDTH-1:0] out_ff [3], out_in [3];
   logic                          sat_ff, sat_in;
   logic                          rsp_valid_ff;

   // advance the whole pipeline unless the result register is held
   assign adv   = !rsp_valid_ff || rsp_chan.ready;
   assign q_pop = adv && q_valid;

   always_comb begin
      logic signed [CxWidth-1:0] p;
      logic signed [KxWidth-1:0] kraw;
      for (int j = 0; j < 3; j++) begin
         p = CxWidth'(q_point[j]);
         if (q_flags.sub_offset) begin
            c_in[j] = p - CxWidth'(offset[j]);
         end else if (q_flags.use_abs && p[CxWidth-1]) begin
            c_in[j] = -p;
         end else begin
            c_in[j] = p;
         end
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if (q_flags.transpose) begin
               kraw = KxWidth'($signed(axis_row[j][i*COEF_WIDTH +: COEF_WIDTH]));
            end else begin
               kraw = KxWidth'($signed(axis_row[i][j*COEF_WIDTH +: COEF_WIDTH]));
            end
            k_in[i][j] = (q_flags.use_abs && kraw[KxWidth-1]) ? -kraw : kraw;
         end
      end
   end

   always_comb begin
      logic signed [PWidth-1:0] prod;
      logic signed [PWidth-1:0] rnd;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod = (PWidth'(hi_p_ff[i][j]) <<< LoWidth) + PWidth'(lo_p_ff[i][j]);
            rnd  = prod + Half;
            term_in[i][j] = $signed(rnd[PWidth-1:FracBits]);
         end
      end
   end

   always_comb begin
      logic signed [AWidth-1:0] acc;
      sat_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         acc = AWidth'(term_ff[i][0]) + AWidth'(term_ff[i][1]) + AWidth'(term_ff[i][2]);
         if (add3_ff) begin
            acc = acc + AWidth'(offset[i]);
         end
         // clip when the bits above the result width are not all sign copies
         if (acc[AWidth-1:COORD_WIDTH-1] == '0 || acc[AWidth-1:COORD_WIDTH-1] == '1) begin
            out_in[i] = acc[COORD_WIDTH-1:0];
         end else begin
            out_in[i] = acc[AWidth-1] ? CoordMin : CoordMax;
            sat_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= q_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_ff    <= c_in;
         k_ff    <= k_in;
         add1_ff <= q_flags.add_offset;
         add2_ff <= add1_ff;
         add3_ff <= add2_ff;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               lo_p_ff[i][j] <= $signed({1'b0, c_ff[j][LoWidth-1:0]}) * k_ff[i][j];
               hi_p_ff[i][j] <= $signed(c_ff[j][CxWidth-1:LoWidth]) * k_ff[i][j];
            end
         end
         term_ff <= term_in;
         out_ff  <= out_in;
         sat_ff  <= sat_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.x_out     = out_ff[0];
   assign rsp_chan.y_out     = out_ff[1];
   assign rsp_chan.z_out     = out_ff[2];
   assign rsp_chan.saturated = sat_ff;

endmodule
